@@ rtl/lpht_pkg.sv @@
// Shared types and codes for the linear-probing hash table.
`default_nettype none
package lpht_pkg;

  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_SET  = 2'd1,
    OP_DEL  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [5:0] MAX_OCC_RESET = 6'd48;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] key;
    logic [63:0] value;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_REM,
    S_START,
    S_PROBE,
    S_DONE
  } fsm_t;

endpackage
`default_nettype wire

@@ rtl/linear_probe_hash_table.sv @@
// Top level of the linear-probing key/value table with tombstones.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  request  | s_axis_tvalid/s_axis_tready  | tuser: operation; tdata: key_id, key_hash,
//           |                              |        value_in
//  result   | m_axis_tvalid/m_axis_tready  | tuser: status, was_new; tdata: read_value
//  config   | cfg_valid/cfg_ready          | cfg_data: max_occupied
//
// Each item probes P slots (1 to CAPACITY) at one slot memory read per cycle; before
// the probe, the S_MUL and S_REM states reduce the hash modulo CAPACITY by reciprocal
// multiply. Unused operations (OP_NONE) skip both and go straight to write-back.
// After reset a clearing pass over every slot empties the slot memory; requests
// wait until it ends, configuration writes are taken at once.
// A finished result is held in the output register; the next request is accepted
// meanwhile, and only the final write-back stage waits for the output to drain.
`default_nettype none
module linear_probe_hash_table #(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // key_id[31:0], key_hash[63:32], value_in[127:64]
  input  logic [1:0]   s_axis_tuser,   // operation[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // read_value[63:0]
  output logic [2:0]   m_axis_tuser,   // status[1:0], was_new[2]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data
);
  import lpht_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $bits(slot_t);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CAPACITY);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  fsm_t state, state_next;

  op_t             op_r;
  logic [31:0]     key_r;
  logic [31:0]     hash_r;
  logic [63:0]     val_r;
  logic [31:0]     q_r;
  logic [AW:0]     rem_r;
  logic [AW-1:0]   cur_idx;
  logic [AW-1:0]   cnt;
  logic            tomb_seen;
  logic [AW-1:0]   tomb_idx;
  logic            found;
  logic            place_ok;
  logic            place_empty;
  logic [AW-1:0]   place_idx;
  logic [AW-1:0]   hit_idx;
  logic [63:0]     hit_value;
  logic [6:0]      occupied;
  logic [5:0]      max_occ;
  logic [AW-1:0]   clr_idx;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  slot_t           ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [SW-1:0]   ram_rdata;
  slot_t           rd;

  logic [63:0]     prod_hi;
  logic [31:0]     prod_qc;
  logic [31:0]     rem_full;
  logic [AW-1:0]   start_idx;
  logic [AW-1:0]   next_idx;
  logic            is_empty, is_hit, is_tomb, is_last, probe_end;
  logic [AW-1:0]   first_tomb;
  logic            out_load;
  status_t         res_status;
  logic            res_was_new;
  logic [63:0]     res_value;
  logic            occ_inc;
  logic            accept;

  lpht_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = slot_t'(ram_rdata);

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // hash mod CAPACITY: q = floor(hash * RECIP / 2^32) is at most one short of the quotient
  assign prod_hi   = 64'(hash_r) * 64'(RECIP);
  assign prod_qc   = q_r * 32'(CAPACITY);
  assign rem_full  = hash_r - prod_qc;
  assign start_idx = (rem_r >= (AW+1)'(CAPACITY)) ? AW'(rem_r - (AW+1)'(CAPACITY))
                                                   : rem_r[AW-1:0];
  assign next_idx  = (cur_idx == LAST_IDX) ? '0 : cur_idx + 1'b1;

  assign is_empty   = (rd.st == SLOT_EMPTY);
  assign is_hit     = (rd.st == SLOT_LIVE) && (rd.key == key_r);
  assign is_tomb    = !is_empty && (rd.st != SLOT_LIVE);
  assign is_last    = (cnt == LAST_IDX);
  assign probe_end  = is_empty || is_hit || is_last;
  assign first_tomb = tomb_seen ? tomb_idx : cur_idx;

  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_waddr   = clr_idx;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = next_idx;
    res_status  = ST_NOT_FOUND;
    res_was_new = 1'b0;
    res_value   = '0;
    occ_inc     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (op_t'(s_axis_tuser) == OP_NONE) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_REM;
      end
      S_REM: begin
        state_next = S_START;
      end
      S_START: begin
        ram_re     = 1'b1;
        ram_raddr  = start_idx;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        // read the following slot ahead; drop it when this one ends the probe
        ram_re = !probe_end;
        if (probe_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        ram_wdata.key = key_r;
        case (op_r)
          OP_GET: begin
            if (found) begin
              res_status = ST_OK;
              res_value  = hit_value;
            end
          end
          OP_DEL: begin
            if (found) begin
              res_status      = ST_OK;
              ram_we          = out_load;
              ram_waddr       = hit_idx;
              ram_wdata.st    = SLOT_TOMB;
              ram_wdata.value = hit_value;
            end
          end
          OP_SET: begin
            ram_wdata.st    = SLOT_LIVE;
            ram_wdata.value = val_r;
            if (found) begin
              res_status = ST_OK;
              ram_we     = out_load;
              ram_waddr  = hit_idx;
            end else if (!place_ok) begin
              res_status = ST_FULL;
            end else if (place_empty &&
                         ({1'b0, occupied} + 8'd1 > {2'b00, max_occ})) begin
              res_status = ST_FULL;
            end else begin
              res_status  = ST_OK;
              res_was_new = 1'b1;
              ram_we      = out_load;
              ram_waddr   = place_idx;
              occ_inc     = out_load && place_empty;
            end
          end
          default: begin
            res_status = ST_NOT_FOUND;
          end
        endcase
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied      <= '0;
      max_occ       <= MAX_OCC_RESET;
      clr_idx       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_occ <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (occ_inc) begin
        occupied <= occupied + 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(s_axis_tuser);
      key_r  <= s_axis_tdata[31:0];
      hash_r <= s_axis_tdata[63:32];
      val_r  <= s_axis_tdata[127:64];
    end
    if (state == S_MUL) begin
      q_r <= prod_hi[63:32];
    end
    if (state == S_REM) begin
      rem_r <= rem_full[AW:0];
    end
    if (state == S_START) begin
      cur_idx   <= start_idx;
      cnt       <= '0;
      tomb_seen <= 1'b0;
    end
    if (state == S_PROBE) begin
      cur_idx <= next_idx;
      cnt     <= cnt + 1'b1;
      if (is_tomb && !tomb_seen) begin
        tomb_seen <= 1'b1;
        tomb_idx  <= cur_idx;
      end
      if (probe_end) begin
        found       <= is_hit;
        hit_idx     <= cur_idx;
        hit_value   <= rd.value;
        place_idx   <= first_tomb;
        place_ok    <= is_empty || tomb_seen || is_tomb;
        place_empty <= is_empty && !tomb_seen;
      end
    end
    if (out_load) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= {res_was_new, res_status};
    end
  end

`ifndef ASSERT_OFF
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_DONE))
    else $error("slot memory written outside clear or write-back");

  a_occ_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (occupied >= $past(occupied)))
    else $error("occupied count went down");

  a_new_is_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == ST_OK))
    else $error("was_new set on a result that is not ok");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_DONE))
    else $error("result raised outside write-back");
`endif

endmodule
`default_nettype wire

@@ rtl/lpht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
